// ----- hdl/pending_request_match_table_defines.svh -----
// ----------------------------------------------------------------------------
// Pending request match table - assertion macros
// Shared property wrappers for the checker of the match table.
// ----------------------------------------------------------------------------
`ifndef PENDING_REQUEST_MATCH_TABLE_DEFINES_SVH
`define PENDING_REQUEST_MATCH_TABLE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define PRMT_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("match table check failed");

// next-cycle implication, disabled while reset is low
`define PRMT_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("match table check failed");

`endif

// ----- hdl/prtm_pkg.sv -----
// ----------------------------------------------------------------------------
// Pending request match table - package
// Operation codes, key layout and the signals passed along the slot chain.
// ----------------------------------------------------------------------------
package prtm_pkg;

    localparam int ID_W   = 32;
    localparam int SOCK_W = 8;
    localparam int PEER_W = 32;

    typedef enum logic [1:0] {
        OP_LOOKUP  = 2'd0,
        OP_TRACK   = 2'd1,
        OP_CONSUME = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [SOCK_W-1:0] sock;
        logic [PEER_W-1:0] peer;
    } t_key;

    // per-beat command broadcast to every slot
    typedef struct packed {
        logic track;
        logic consume;
        logic clear;
    } t_cell_cmd;

    // running state handed from one slot to the next
    typedef struct packed {
        logic hit_seen;
        logic free_seen;
        logic any_active;
    } t_chain;

endpackage

// ----- hdl/prtm_cell.sv -----
// ----------------------------------------------------------------------------
// Pending request match table - slot cell
// One slot: active bit and key, key compare, and its link in the priority chain.
// ----------------------------------------------------------------------------
module prtm_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  prtm_pkg::t_key      i_key,
    input  prtm_pkg::t_cell_cmd i_cmd,
    input  logic                i_matched,
    input  prtm_pkg::t_chain    i_chain,
    output prtm_pkg::t_chain    o_chain
);
    import prtm_pkg::*;

    logic r_active;
    logic n_active;
    t_key r_key;
    logic hit;
    logic take;

    assign hit = r_active && (r_key == i_key);

    // refresh the first matching slot, else claim the first free one
    assign take = i_cmd.track &&
                  (i_matched ? (hit && !i_chain.hit_seen)
                             : (!r_active && !i_chain.free_seen));

    always_comb begin
        n_active = r_active;
        priority if (i_cmd.clear) begin
            n_active = 1'b0;
        end else if (i_cmd.consume && hit) begin
            n_active = 1'b0;
        end else if (take) begin
            n_active = 1'b1;
        end
    end

    assign o_chain.hit_seen   = i_chain.hit_seen  | hit;
    assign o_chain.free_seen  = i_chain.free_seen | !r_active;
    assign o_chain.any_active = i_chain.any_active | n_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else begin
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_key <= i_key;
        end
    end

endmodule

// ----- hdl/pending_request_match_table.sv -----
// ----------------------------------------------------------------------------
// Pending request match table - top level
// Content-addressed table of outstanding requests built as a row of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_operation and the key (i_request_id, i_socket_handle,
//   i_peer_address) and raise start; the beat is taken on a clock edge where
//   busy is low. Operations: lookup, track, consume, clear.
//   Exactly one result follows per beat, in the cycle after acceptance, shown
//   for one cycle with o_result_valid high. Throughput is one beat per cycle
//   while busy is low: every slot compares its key in parallel and the
//   hit/free priority runs as a ripple through the SLOT_COUNT cells, which
//   sets the combinational path length.
//   The receiver cannot stall; results must be taken when the strobe shows.
//   Synchronous reset frees all slots, clears the valid, pending and tracked
//   flags and expected key; busy stays high through reset until r_live is set.
// ----------------------------------------------------------------------------
module pending_request_match_table #(
    parameter int SLOT_COUNT = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_operation,
    input  logic signed [31:0]          i_request_id,
    input  logic [7:0]                  i_socket_handle,
    input  logic [31:0]                 i_peer_address,
    output logic                        o_result_valid,
    output logic                        o_key_matched,
    output logic                        o_can_track,
    output logic                        o_stored,
    output logic                        o_request_pending,
    output logic                        o_tracking_enabled,
    output logic                        o_request_tracked,
    output logic signed [31:0]          o_expected_id,
    output logic [7:0]                  o_expected_socket,
    output logic [31:0]                 o_expected_peer
);
    import prtm_pkg::*;

    logic      r_live;
    logic      accept;
    t_op       op;
    t_key      key;
    t_cell_cmd cmd;
    t_chain    chain [SLOT_COUNT+1];
    logic      matched;
    logic      trackable;
    logic      do_store;

    logic      r_valid;
    logic      r_matched;
    logic      r_can_track;
    logic      r_stored;
    logic      r_pending;
    logic      r_tracked;
    t_key      r_last;

    assign busy   = !r_live;
    assign accept = start && !busy;
    assign op     = t_op'(i_operation);

    assign key.id   = i_request_id;
    assign key.sock = i_socket_handle;
    assign key.peer = i_peer_address;

    always_comb begin
        cmd = '0;
        unique case (op)
            OP_LOOKUP:  cmd = '0;
            OP_TRACK:   cmd.track   = accept;
            OP_CONSUME: cmd.consume = accept;
            OP_CLEAR:   cmd.clear   = accept;
            default:    cmd = '0;
        endcase
    end

    assign chain[0] = '0;

    genvar g;
    generate
        for (g = 0; g < SLOT_COUNT; g++) begin : g_slot
            prtm_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_key     (key),
                .i_cmd     (cmd),
                .i_matched (matched),
                .i_chain   (chain[g]),
                .o_chain   (chain[g+1])
            );
        end
    endgenerate

    assign matched   = chain[SLOT_COUNT].hit_seen;
    assign trackable = matched || chain[SLOT_COUNT].free_seen;
    assign do_store  = cmd.track && trackable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live    <= 1'b0;
            r_valid   <= 1'b0;
            r_pending <= 1'b0;
            r_tracked <= 1'b0;
            r_last    <= '0;
        end else begin
            r_live  <= 1'b1;
            r_valid <= accept;
            if (accept) begin
                r_pending <= chain[SLOT_COUNT].any_active;
            end
            if (do_store) begin
                r_tracked <= 1'b1;
                r_last    <= key;
            end
        end
    end

    // per-beat status, held until the next beat
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_matched   <= matched;
            r_can_track <= trackable;
            r_stored    <= do_store;
        end
    end

    assign o_result_valid     = r_valid;
    assign o_key_matched      = r_matched;
    assign o_can_track        = r_can_track;
    assign o_stored           = r_stored;
    assign o_request_pending  = r_pending;
    assign o_tracking_enabled = r_tracked;
    assign o_request_tracked  = r_tracked;
    assign o_expected_id      = r_last.id;
    assign o_expected_socket  = r_last.sock;
    assign o_expected_peer    = r_last.peer;

endmodule

// ----- hdl/prtm_checker.sv -----
// ----------------------------------------------------------------------------
// Pending request match table - port checker
// Watches the top-level ports for result timing and flag consistency.
// ----------------------------------------------------------------------------
`include "pending_request_match_table_defines.svh"

module prtm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_result_valid,
    input logic                o_key_matched,
    input logic                o_can_track,
    input logic                o_stored,
    input logic                o_request_pending,
    input logic                o_tracking_enabled,
    input logic                o_request_tracked
);

    // every accepted beat yields a result on the next cycle
    `PRMT_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, start && !busy, o_result_valid)

    // no result without an accepted beat
    `PRMT_ASSERT_NEXT(a_no_spurious, i_clk, i_rst_n, !(start && !busy), !o_result_valid)

    // a stored beat needed room and leaves the table pending and tracking
    `PRMT_ASSERT_NOW(a_store_flags, i_clk, i_rst_n, o_result_valid && o_stored,
        o_can_track && o_request_pending && o_tracking_enabled && o_request_tracked)

    // a match always means the key can be tracked
    `PRMT_ASSERT_NOW(a_match_trackable, i_clk, i_rst_n, o_result_valid && o_key_matched,
        o_can_track)

endmodule

bind pending_request_match_table prtm_checker u_prtm_checker (.*);
